// ===== rtl/tht_pkg.sv =====
// ----------------------------------------------------------------------------
// tht_pkg: shared definitions for the tombstone hash table
// Table size, slot kind codes, operation codes and the command and status
// structures that join the controller and the datapath.
// ----------------------------------------------------------------------------
package tht_pkg;

    // The table size must be a power of two: the home slot is the low tag bits.
    localparam int TABLE_SLOTS = 256;
    localparam int SLOT_W      = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
    localparam int TAG_W       = 64;
    localparam int HANDLE_W    = 64;

    localparam logic [1:0] KIND_EMPTY     = 2'd0;
    localparam logic [1:0] KIND_OCCUPIED  = 2'd1;
    localparam logic [1:0] KIND_TOMBSTONE = 2'd2;

    localparam logic OP_PUT  = 1'b0;
    localparam logic OP_TAKE = 1'b1;

    typedef logic [SLOT_W-1:0] slot_idx_t;

    typedef struct packed {
        logic [1:0]          kind;
        logic [TAG_W-1:0]    tag;
        logic [HANDLE_W-1:0] handle;
    } slot_row_t;

    // Controller to datapath.
    typedef struct packed {
        logic load;         // latch a new transaction and reset the probe
        logic rd;           // read the slot at the probe position
        logic note_tomb;    // remember the probe position as first tombstone
        logic advance;      // move the probe to the next slot
        logic wr;           // write a slot
        logic wr_tomb_kind; // the write turns the slot into a tombstone
        logic wr_at_tomb;   // write at the remembered tombstone, not the probe
        logic done;         // capture the result
        logic ok;           // result success flag
    } tht_cmd_t;

    // Datapath to controller.
    typedef struct packed {
        logic       op;
        logic [1:0] kind;
        logic       tag_match;
        logic       last;
        logic       have_tomb;
    } tht_sts_t;

endpackage

// ===== rtl/tht_dpath.sv =====
// ----------------------------------------------------------------------------
// tht_dpath: slot memory and probe datapath
// Holds the slot memory, the per-slot valid bits, the probe position and
// counter, the first-tombstone register and the result registers.
// ----------------------------------------------------------------------------
module tht_dpath import tht_pkg::*; (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_op,
    input  logic [TAG_W-1:0]    s_tag,
    input  logic [HANDLE_W-1:0] s_handle,
    input  tht_cmd_t            cmd,
    output tht_sts_t            sts,
    output logic                m_success,
    output logic [HANDLE_W-1:0] m_handle_out
);

    slot_row_t                slot_mem [TABLE_SLOTS];
    logic [TABLE_SLOTS-1:0]   kind_vld_reg;
    slot_row_t                rd_row_reg;
    logic                     rd_vld_reg;

    logic                     op_reg;
    logic [TAG_W-1:0]         tag_reg;
    logic [HANDLE_W-1:0]      handle_reg;
    slot_idx_t                slot_reg;
    slot_idx_t                tomb_reg;
    slot_idx_t                cnt_reg;
    logic                     have_tomb_reg;
    logic                     success_reg;
    logic [HANDLE_W-1:0]      handle_out_reg;

    slot_idx_t                wr_addr;
    slot_row_t                wr_row;
    slot_idx_t                slot_next;

    assign wr_addr = cmd.wr_at_tomb ? tomb_reg : slot_reg;

    always_comb begin
        if (cmd.wr_tomb_kind) begin
            wr_row.kind   = KIND_TOMBSTONE;
            wr_row.tag    = '0;
            wr_row.handle = '0;
        end else begin
            wr_row.kind   = KIND_OCCUPIED;
            wr_row.tag    = tag_reg;
            wr_row.handle = handle_reg;
        end
    end

    assign slot_next = (slot_reg == SLOT_W'(TABLE_SLOTS - 1)) ? '0 : slot_reg + 1'b1;

    // Slot memory: one write and one registered read per cycle.
    always_ff @(posedge aclk) begin
        if (cmd.wr) begin
            slot_mem[wr_addr] <= wr_row;
        end
        if (cmd.rd) begin
            rd_row_reg <= slot_mem[slot_reg];
            rd_vld_reg <= kind_vld_reg[slot_reg];
        end
    end

    // A slot never written reads as empty.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            kind_vld_reg <= '0;
        end else if (cmd.wr) begin
            kind_vld_reg[wr_addr] <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            have_tomb_reg <= 1'b0;
        end else if (cmd.load) begin
            have_tomb_reg <= 1'b0;
        end else if (cmd.note_tomb) begin
            have_tomb_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            op_reg     <= s_op;
            tag_reg    <= s_tag;
            handle_reg <= s_handle;
            slot_reg   <= s_tag[SLOT_W-1:0];
            cnt_reg    <= '0;
        end else if (cmd.advance) begin
            slot_reg <= slot_next;
            cnt_reg  <= cnt_reg + 1'b1;
        end
        if (cmd.note_tomb) begin
            tomb_reg <= slot_reg;
        end
        if (cmd.done) begin
            success_reg    <= cmd.ok;
            handle_out_reg <= (cmd.ok && (op_reg == OP_TAKE)) ? rd_row_reg.handle : '0;
        end
    end

    assign sts.op        = op_reg;
    assign sts.kind      = rd_vld_reg ? rd_row_reg.kind : KIND_EMPTY;
    assign sts.tag_match = (rd_row_reg.tag == tag_reg);
    assign sts.last      = (cnt_reg == SLOT_W'(TABLE_SLOTS - 1));
    assign sts.have_tomb = have_tomb_reg;

    assign m_success    = success_reg;
    assign m_handle_out = handle_out_reg;

endmodule

// ===== rtl/tht_ctrl.sv =====
// ----------------------------------------------------------------------------
// tht_ctrl: probe sequencer
// Steps each transaction through read and evaluate states, one slot per
// probe, and owns the input ready and the result valid.
// ----------------------------------------------------------------------------
module tht_ctrl import tht_pkg::*; (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    output logic     m_valid,
    input  logic     m_ready,
    input  tht_sts_t sts,
    output tht_cmd_t cmd
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_READ = 2'd1;
    localparam logic [1:0] ST_EVAL = 2'd2;

    logic [1:0] state_reg, state_next;
    logic       m_valid_reg, m_valid_next;

    logic out_free;
    logic is_put, put_empty, put_first_tomb, take_hit, take_empty;

    assign s_ready  = (state_reg == ST_IDLE);
    assign m_valid  = m_valid_reg;
    assign out_free = !m_valid_reg || m_ready;

    assign is_put         = (sts.op == OP_PUT);
    assign put_empty      = is_put && (sts.kind == KIND_EMPTY);
    assign put_first_tomb = is_put && (sts.kind == KIND_TOMBSTONE) && !sts.have_tomb;
    assign take_hit       = !is_put && (sts.kind == KIND_OCCUPIED) && sts.tag_match;
    assign take_empty     = !is_put && (sts.kind == KIND_EMPTY);

    always_comb begin
        cmd          = '0;
        state_next   = state_reg;
        m_valid_next = m_valid_reg;
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    state_next = ST_READ;
                end
            end
            ST_READ: begin
                cmd.rd     = 1'b1;
                state_next = ST_EVAL;
            end
            ST_EVAL: begin
                if (put_empty || take_hit || take_empty || sts.last) begin
                    // Finishing: wait here until the result register is free.
                    if (out_free) begin
                        cmd.done     = 1'b1;
                        m_valid_next = 1'b1;
                        state_next   = ST_IDLE;
                        if (put_empty) begin
                            cmd.wr         = 1'b1;
                            cmd.wr_at_tomb = sts.have_tomb;
                            cmd.ok         = 1'b1;
                        end else if (take_hit) begin
                            cmd.wr           = 1'b1;
                            cmd.wr_tomb_kind = 1'b1;
                            cmd.ok           = 1'b1;
                        end else if (is_put && (sts.have_tomb || put_first_tomb)) begin
                            // Whole probe without an empty slot: reuse a tombstone.
                            cmd.wr         = 1'b1;
                            cmd.wr_at_tomb = sts.have_tomb;
                            cmd.ok         = 1'b1;
                        end
                    end
                end else begin
                    cmd.note_tomb = put_first_tomb;
                    cmd.advance   = 1'b1;
                    state_next    = ST_READ;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

endmodule

// ===== rtl/tombstone_hash_table.sv =====
// Each transaction probes P slots (1 to 256); a new transaction is accepted only while idle,
// after the previous one has finished its probe. Each probe is one slot memory read
// followed by an evaluate state in the controller.
// Reset: synchronous active-low aresetn clears the state machine, the result valid and
// all slot valid bits at once, so every slot reads empty; no clearing pass is needed.
// ----------------------------------------------------------------------------
// tombstone_hash_table: tag-to-handle table with linear probing
// Open-addressing hash table with tombstones. A put stores a tag and handle,
// a take looks a tag up, returns its handle and leaves a tombstone.
// ----------------------------------------------------------------------------
module tombstone_hash_table import tht_pkg::*; (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic                s_op,
    input  logic [TAG_W-1:0]    s_tag,
    input  logic [HANDLE_W-1:0] s_handle,
    output logic                m_valid,
    input  logic                m_ready,
    output logic                m_success,
    output logic [HANDLE_W-1:0] m_handle_out
);

    // The controller sequences each transaction: it accepts it while idle,
    // then alternates a read of the probed slot with an evaluation of the
    // registered slot contents. The datapath keeps the probe position, the
    // first tombstone seen by a put, and the slot memory with its valid bits.
    tht_cmd_t cmd;
    tht_sts_t sts;

    // A finished result stays in the datapath result registers while the
    // controller already takes the next transaction; a later finish waits
    // until that result has been taken.
    tht_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    tht_dpath u_dpath (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_op         (s_op),
        .s_tag        (s_tag),
        .s_handle     (s_handle),
        .cmd          (cmd),
        .sts          (sts),
        .m_success    (m_success),
        .m_handle_out (m_handle_out)
    );

endmodule

// ===== rtl/tht_checker.sv =====
// ----------------------------------------------------------------------------
// tht_checker: port-level assertions for the tombstone hash table
// Watches the top-level ports only and is bound to the top level.
// ----------------------------------------------------------------------------
module tht_checker import tht_pkg::*; (
    input logic                aclk,
    input logic                aresetn,
    input logic                s_valid,
    input logic                s_ready,
    input logic                s_op,
    input logic [TAG_W-1:0]    s_tag,
    input logic [HANDLE_W-1:0] s_handle,
    input logic                m_valid,
    input logic                m_ready,
    input logic                m_success,
    input logic [HANDLE_W-1:0] m_handle_out
);

    // A waiting input transaction keeps its payload until it is accepted.
    a_input_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && !s_ready |=>
            s_valid && $stable(s_op) && $stable(s_tag) && $stable(s_handle))
        else $error("input payload changed while waiting");

    // A waiting result holds its value until taken.
    a_result_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_success) && $stable(m_handle_out))
        else $error("result changed while stalled");

    // A failed transaction never returns a handle.
    a_fail_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_success |-> m_handle_out == '0)
        else $error("failed transaction returned a nonzero handle");

    // Reset leaves the block idle with no result pending.
    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> s_ready && !m_valid)
        else $error("block not idle after reset");

    // An accepted transaction keeps the block busy for at least one probe.
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input ready right after acceptance");

endmodule

bind tombstone_hash_table tht_checker u_tht_checker (
    .aclk         (aclk),
    .aresetn      (aresetn),
    .s_valid      (s_valid),
    .s_ready      (s_ready),
    .s_op         (s_op),
    .s_tag        (s_tag),
    .s_handle     (s_handle),
    .m_valid      (m_valid),
    .m_ready      (m_ready),
    .m_success    (m_success),
    .m_handle_out (m_handle_out)
);

// ===== sim/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the tombstone hash table
// Drives put and take transactions into the table and keeps a mirror of
// every slot. Each returned result is compared with the one the mirror
// predicts. The stimulus walks the table from empty to full and back, and
// reuses tombstones. The sender and receiver pause at random.
// ----------------------------------------------------------------------------
module tb_top;
    import tht_pkg::*;

    // The longest correct stretch without any transaction is one full-table
    // probe plus a sender gap and a receiver stall. The limit allows several
    // times that.
    localparam int IDLE_LIMIT   = 4000;
    localparam int SETTLE_WAIT  = 2 * TABLE_SLOTS + 100;
    localparam int TARGET_OPS   = 1250;
    localparam int REPORT_LIMIT = 10;

    typedef struct {
        logic                op;
        logic [TAG_W-1:0]    tag;
        logic [HANDLE_W-1:0] hdl;
        bit                  drain; // hold this one back until all replies are in
    } table_op_t;

    typedef struct packed {
        logic                success;
        logic [HANDLE_W-1:0] handle_out;
    } table_reply_t;

    logic                aclk    = 1'b0;
    logic                aresetn = 1'b0;
    logic                s_valid = 1'b0;
    logic                s_ready;
    logic                s_op    = OP_PUT;
    logic [TAG_W-1:0]    s_tag   = '0;
    logic [HANDLE_W-1:0] s_handle = '0;
    logic                m_valid;
    logic                m_ready = 1'b0;
    logic                m_success;
    logic [HANDLE_W-1:0] m_handle_out;

    tombstone_hash_table u_top (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_op         (s_op),
        .s_tag        (s_tag),
        .s_handle     (s_handle),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_success    (m_success),
        .m_handle_out (m_handle_out)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // Transactions still to be sent, and the replies the mirror predicts for
    // the transactions already accepted, oldest first.
    table_op_t         op_q[$];
    table_reply_t      reply_q[$];
    // Tags the stimulus believes are stored, so that takes can aim at them.
    logic [TAG_W-1:0]  live_tags[$];
    slot_row_t         mirror_slots [TABLE_SLOTS];

    int error_count  = 0;
    int accepted_ops = 0;
    int total_ops    = 0;

    // ------------------------------------------------------------------------
    // Mirror of the table. Applies one transaction to the slot copy and
    // returns the reply the block has to give for it.
    // ------------------------------------------------------------------------
    function automatic table_reply_t run_table_op(logic op, logic [TAG_W-1:0] tag,
                                                  logic [HANDLE_W-1:0] hdl);
        table_reply_t reply;
        int           home;
        int           s;
        int           target;
        bit           have_tomb;
        bit           stop;
        reply     = '0;
        home      = int'(tag % TABLE_SLOTS);
        target    = 0;
        have_tomb = 1'b0;
        stop      = 1'b0;
        if (op == OP_PUT) begin
            // The first tombstone wins if it comes before the first empty
            // slot. Without any empty slot it is still used as a fallback.
            for (int i = 0; i < TABLE_SLOTS && !stop; i++) begin
                s = (home + i) % TABLE_SLOTS;
                if (mirror_slots[s].kind == KIND_TOMBSTONE && !have_tomb) begin
                    have_tomb = 1'b1;
                    target    = s;
                end else if (mirror_slots[s].kind == KIND_EMPTY) begin
                    if (!have_tomb)
                        target = s;
                    stop = 1'b1;
                end
            end
            if (stop || have_tomb) begin
                mirror_slots[target].kind   = KIND_OCCUPIED;
                mirror_slots[target].tag    = tag;
                mirror_slots[target].handle = hdl;
                reply.success = 1'b1;
            end
        end else begin
            // A take stops at the first matching occupied slot or at an empty
            // slot; tombstones are stepped over.
            for (int i = 0; i < TABLE_SLOTS && !stop; i++) begin
                s = (home + i) % TABLE_SLOTS;
                if (mirror_slots[s].kind == KIND_OCCUPIED && mirror_slots[s].tag == tag) begin
                    reply.success               = 1'b1;
                    reply.handle_out            = mirror_slots[s].handle;
                    mirror_slots[s].kind   = KIND_TOMBSTONE;
                    mirror_slots[s].tag    = '0;
                    mirror_slots[s].handle = '0;
                    stop = 1'b1;
                end else if (mirror_slots[s].kind == KIND_EMPTY) begin
                    stop = 1'b1;
                end
            end
        end
        return reply;
    endfunction

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------
    task automatic queue_op(logic op, logic [TAG_W-1:0] tag, logic [HANDLE_W-1:0] hdl,
                            bit drain);
        table_op_t item;
        item.op    = op;
        item.tag   = tag;
        item.hdl   = hdl;
        item.drain = drain;
        op_q.push_back(item);
        // Track what should be stored: a put into a full table is dropped, a
        // take removes the first copy of its tag.
        if (op == OP_PUT) begin
            if (live_tags.size() < TABLE_SLOTS)
                live_tags.push_back(tag);
        end else begin
            for (int i = 0; i < live_tags.size(); i++) begin
                if (live_tags[i] == tag) begin
                    live_tags.delete(i);
                    break;
                end
            end
        end
    endtask

    function automatic logic [HANDLE_W-1:0] rand_handle();
        case ($urandom_range(0, 15))
            0:       return '0;
            1:       return '1;
            default: return {$urandom(), $urandom()};
        endcase
    endfunction

    // A clustered tag lands near the bottom or the top of the table, so that
    // probe chains grow long and wrap around the end.
    function automatic logic [TAG_W-1:0] rand_tag(bit clustered);
        logic [TAG_W-1:0] t;
        slot_idx_t        home;
        t = {$urandom(), $urandom()};
        if (clustered) begin
            if ($urandom_range(0, 1) == 0)
                home = slot_idx_t'($urandom_range(0, 11));
            else
                home = slot_idx_t'(TABLE_SLOTS - 1 - $urandom_range(0, 5));
            t[SLOT_W-1:0] = home;
        end
        return t;
    endfunction

    task automatic take_live(bit drain);
        queue_op(OP_TAKE, live_tags[$urandom_range(0, live_tags.size() - 1)],
                 rand_handle(), drain);
    endtask

    // Mixed traffic: puts with probability put_pct percent, otherwise takes
    // that mostly hit a stored tag and sometimes miss.
    task automatic churn(int count, int put_pct);
        for (int n = 0; n < count; n++) begin
            if (live_tags.size() == 0 || $urandom_range(0, 99) < put_pct)
                queue_op(OP_PUT, rand_tag($urandom_range(0, 1)), rand_handle(), n == 0);
            else if ($urandom_range(0, 4) == 0)
                queue_op(OP_TAKE, rand_tag($urandom_range(0, 1)), rand_handle(), n == 0);
            else
                take_live(n == 0);
        end
    endtask

    // ------------------------------------------------------------------------
    // Sender. Holds each transaction for a random gap, and holds a marked one
    // back until every outstanding reply has come. A transaction is predicted
    // at the edge where it is accepted.
    // ------------------------------------------------------------------------
    table_op_t cur_op;
    bit        op_loaded;
    bit        send_quiet = 1'b0;
    bit        drain_hold;
    int        send_gap;

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
            op_loaded = 1'b0;
            send_gap  = 0;
            foreach (mirror_slots[k])
                mirror_slots[k] = '0;
        end else if (!(s_valid && !s_ready)) begin
            if (s_valid) begin
                reply_q.push_back(run_table_op(cur_op.op, cur_op.tag, cur_op.hdl));
                accepted_ops++;
                op_loaded = 1'b0;
            end
            if (!op_loaded && op_q.size() > 0) begin
                cur_op    = op_q.pop_front();
                op_loaded = 1'b1;
                // Switch now and then between gapped traffic and back-to-back.
                if ($urandom_range(0, 39) == 0)
                    send_quiet = !send_quiet;
                send_gap = send_quiet ? 0 : $urandom_range(0, 14);
            end
            drain_hold = op_loaded && cur_op.drain && reply_q.size() != 0;
            if (op_loaded && !drain_hold && send_gap == 0) begin
                s_valid  <= 1'b1;
                s_op     <= cur_op.op;
                s_tag    <= cur_op.tag;
                s_handle <= cur_op.hdl;
            end else begin
                s_valid <= 1'b0;
                if (op_loaded && !drain_hold)
                    send_gap--;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Receiver. Stalls a random number of cycles after each result and checks
    // every result against the oldest predicted reply.
    // ------------------------------------------------------------------------
    table_reply_t want;
    bit           recv_quiet = 1'b0;
    int           recv_gap;

    task automatic flag_error(string msg);
        if (error_count < REPORT_LIMIT)
            $display("[%0t] ERROR: %s", $realtime, msg);
        error_count++;
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
            recv_gap = 0;
        end else begin
            if (m_valid && m_ready) begin
                if (reply_q.size() == 0) begin
                    flag_error($sformatf("result with nothing outstanding: success=%0b handle=%h",
                                         m_success, m_handle_out));
                end else begin
                    want = reply_q.pop_front();
                    if (m_success !== want.success)
                        flag_error($sformatf("success: expected %0b, got %0b",
                                             want.success, m_success));
                    if (m_handle_out !== want.handle_out)
                        flag_error($sformatf("handle_out: expected %h, got %h",
                                             want.handle_out, m_handle_out));
                end
                if ($urandom_range(0, 39) == 0)
                    recv_quiet = !recv_quiet;
                recv_gap = recv_quiet ? 0 : $urandom_range(0, 14);
            end
            if (recv_gap > 0) begin
                recv_gap--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // Watchdog: ends the run if no transaction moves on either side for too
    // long.
    int idle_cycles = 0;

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus and end of run
    // ------------------------------------------------------------------------
    initial begin
        logic [TAG_W-1:0] tag_top_a;
        logic [TAG_W-1:0] tag_top_b;

        // Directed part. Tags 0, TABLE_SLOTS, 2*TABLE_SLOTS and 3*TABLE_SLOTS
        // share home slot 0; the all-ones tag and the two built below live at
        // the last slot, so their chain wraps to the start.
        tag_top_a = {$urandom(), $urandom()};
        tag_top_a[SLOT_W-1:0] = '1;
        tag_top_b = {$urandom(), $urandom()};
        tag_top_b[SLOT_W-1:0] = '1;

        queue_op(OP_TAKE, '0, '1, 1'b0);                      // miss on an empty table
        queue_op(OP_PUT,  '0, '0, 1'b0);                      // zero tag, zero handle
        queue_op(OP_PUT,  '1, '1, 1'b0);                      // all-ones tag and handle
        queue_op(OP_PUT,  TAG_W'(TABLE_SLOTS), {32{2'b01}}, 1'b0);
        queue_op(OP_PUT,  '0, HANDLE_W'(1), 1'b0);            // duplicate tag
        queue_op(OP_TAKE, '0, '0, 1'b0);                      // finds the zero handle
        queue_op(OP_TAKE, '0, '0, 1'b0);                      // second copy, past a tombstone
        queue_op(OP_TAKE, '0, '0, 1'b0);                      // miss across tombstones
        queue_op(OP_PUT,  TAG_W'(2 * TABLE_SLOTS), {32{2'b10}}, 1'b0); // reuses a tombstone
        queue_op(OP_TAKE, '1, '0, 1'b0);
        queue_op(OP_PUT,  tag_top_a, rand_handle(), 1'b0);    // tombstone in the last slot
        queue_op(OP_PUT,  tag_top_b, rand_handle(), 1'b0);    // probe wraps to the start
        queue_op(OP_TAKE, tag_top_b, rand_handle(), 1'b0);    // take across the wrap
        queue_op(OP_TAKE, TAG_W'(3 * TABLE_SLOTS), '1, 1'b0);
        queue_op(OP_TAKE, TAG_W'(TABLE_SLOTS), '0, 1'b0);
        queue_op(OP_TAKE, TAG_W'(2 * TABLE_SLOTS), '0, 1'b0);
        queue_op(OP_TAKE, tag_top_a, '0, 1'b1);

        // Mixed traffic on a partly filled table.
        churn(480, 55);

        // Fill every slot, then keep putting so that some puts are dropped,
        // and look up tags that are not there while nothing is empty.
        for (int n = TABLE_SLOTS - live_tags.size() + 6; n > 0; n--)
            queue_op(OP_PUT, rand_tag($urandom_range(0, 3) == 0), rand_handle(), 1'b0);
        queue_op(OP_TAKE, rand_tag(1'b0), rand_handle(), 1'b0);
        queue_op(OP_TAKE, rand_tag(1'b1), rand_handle(), 1'b0);

        // No empty slot left: puts can only fall back to tombstones that the
        // takes leave behind.
        for (int n = 0; n < 110; n++) begin
            case ($urandom_range(0, 4))
                0, 1:    take_live(n == 0);
                2, 3:    queue_op(OP_PUT, rand_tag($urandom_range(0, 1)), rand_handle(), n == 0);
                default: queue_op(OP_TAKE, rand_tag(1'b0), rand_handle(), n == 0);
            endcase
        end

        // Empty the table again, with a few misses along the way.
        queue_op(OP_TAKE, rand_tag(1'b0), rand_handle(), 1'b1);
        while (live_tags.size() > 0) begin
            take_live(1'b0);
            if ($urandom_range(0, 7) == 0)
                queue_op(OP_TAKE, rand_tag($urandom_range(0, 1)), rand_handle(), 1'b0);
        end

        // The rest runs on a table that is mostly tombstones.
        if (op_q.size() < TARGET_OPS)
            churn(TARGET_OPS - op_q.size(), 50);
        total_ops = op_q.size();

        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        wait (accepted_ops == total_ops);
        wait (reply_q.size() == 0);
        // Anything the block still sends after this point is unexpected.
        repeat (SETTLE_WAIT) @(posedge aclk);

        if (error_count == 0 && reply_q.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
